FILE: hdl/tcpa_pkg.sv
`timescale 1ns / 1ps

package tcpa_pkg;

   localparam int NODE_BITS     = 6;
   localparam int STAMP_IN_BITS = 32;
   localparam int MASK_BITS     = 64;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_RESOLVE = 1'b1;

   localparam logic [1:0] KIND_RAW     = 2'd0;
   localparam logic [1:0] KIND_WAW     = 2'd1;
   localparam logic [1:0] KIND_WAR     = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic                     func;
      logic [NODE_BITS-1:0]     node;
      logic [STAMP_IN_BITS-1:0] stamp;
      logic [1:0]               conflict_kind;
      logic [NODE_BITS-1:0]     single_defender;
      logic [MASK_BITS-1:0]     reader_mask;
   } req_word_type;

   typedef struct packed {
      logic                 attacker_wins;
      logic [MASK_BITS-1:0] abort_mask;
   } rsp_word_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic                 wr_en;
      logic                 cmp_en;
      logic [NODE_BITS-1:0] att_node;
   } lane_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MERGE
   } state_type;

endpackage

FILE: hdl/tcpa_ram.sv
`timescale 1ns / 1ps

module tcpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tcpa_lane.sv
`timescale 1ns / 1ps

module tcpa_lane
   import tcpa_pkg::*;
#(
   parameter int STAMP_BITS = 32,
   parameter int LANE_ID    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lane_ctrl_type         ctrl,
   input  logic [STAMP_BITS-1:0] wr_stamp,
   input  logic [STAMP_BITS-1:0] att_stamp,
   output logic                  beats_att
);

   localparam logic [NODE_BITS-1:0] LANE_NODE = NODE_BITS'(LANE_ID);

   logic [STAMP_BITS-1:0] stamp_ff;
   logic [STAMP_BITS-1:0] stamp_in;
   logic                  beats_ff;
   logic                  beats_in;

   always_comb begin
      stamp_in = ctrl.wr_en ? wr_stamp : stamp_ff;
      // lower stamp wins, ties go to the lower node id
      beats_in = (stamp_ff < att_stamp) ||
                 ((stamp_ff == att_stamp) && (LANE_NODE < ctrl.att_node));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else begin
         stamp_ff <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         beats_ff <= beats_in;
      end
   end

   assign beats_att = beats_ff;

endmodule

FILE: hdl/tcpa_merge.sv
`timescale 1ns / 1ps

module tcpa_merge
   import tcpa_pkg::*;
#(
   parameter int NODES = 64
) (
   input  req_word_type           item,
   input  logic [((NODES < MASK_BITS) ? NODES : MASK_BITS)-1:0] beat,
   output rsp_word_type           result
);

   localparam int LANES = (NODES < MASK_BITS) ? NODES : MASK_BITS;
   localparam int IDX_W = $clog2(LANES);

   logic             node_ok;
   logic             def_ok;
   logic [LANES-1:0] att_oh;
   logic [LANES-1:0] readers;
   logic             lost;

   always_comb begin
      node_ok = int'(item.node) < NODES;
      def_ok  = int'(item.single_defender) < NODES;
      att_oh  = LANES'(1) << item.node;
      readers = item.reader_mask[LANES-1:0] & ~att_oh;
      lost    = |(beat & readers);

      result = '0;
      if (item.func == FUNC_RESOLVE && node_ok) begin
         unique case (item.conflict_kind)
            KIND_RAW, KIND_WAW: begin
               // attacker beats defender iff they differ and defender does not beat it
               if (def_ok && (item.single_defender != item.node) &&
                   !beat[item.single_defender[IDX_W-1:0]]) begin
                  result.attacker_wins = 1'b1;
                  result.abort_mask    = MASK_BITS'(1) << item.single_defender;
               end
            end
            KIND_WAR: begin
               if (!lost) begin
                  result.attacker_wins = 1'b1;
                  result.abort_mask    = MASK_BITS'(readers);
               end
            end
            KIND_UNKNOWN: begin
               result = '0;
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

endmodule

FILE: hdl/tx_conflict_priority_arbiter_core.sv
`timescale 1ns / 1ps
// transaction conflict arbiter: one start stamp per node, lowest stamp wins
// req channel (req_valid / req_stall / req_word): func 0 writes a node's stamp,
// func 1 resolves a conflict for the attacking node against one defender
// (read-after-write, write-after-write) or against all readers in a mask
// (write-after-read). every request word yields exactly one response word.
// rsp channel (rsp_valid / rsp_stall / rsp_word): win flag plus abort mask;
// update words answer with all zeros.
// a resolve runs in steps: the attacker's stamp is read from a stamp ram,
// then one comparator lane per node checks its own stamp against it, then the
// lane results are merged into the response register; updates skip the compare.
// one word is in flight at a time, so req_stall is high from acceptance until
// the merge step has loaded the output register; that register lets the next
// word be accepted while an earlier response still waits.
// when the receiver stalls, rsp_word holds and the merge step waits for the
// output register to free up. reset clears all stamps to zero (valid bits
// cover the ram copy) and leaves the block idle with no response pending.
module tx_conflict_priority_arbiter_core
   import tcpa_pkg::*;
#(
   parameter int NODES      = 64,
   parameter int STAMP_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int LANES = (NODES < MASK_BITS) ? NODES : MASK_BITS;
   localparam int IDX_W = $clog2(LANES);

   state_type             state_ff;
   state_type             state_in;
   req_word_type          item_ff;
   logic [LANES-1:0]      valid_ff;
   logic [LANES-1:0]      valid_in;
   rsp_word_type          rsp_ff;
   rsp_word_type          rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  accept;
   logic                  wr_en;
   logic                  cmp_en;
   logic                  rsp_load;
   logic [STAMP_BITS-1:0] wr_stamp;
   logic [STAMP_BITS-1:0] ram_rdata;
   logic [STAMP_BITS-1:0] att_stamp;
   logic [LANES-1:0]      beat;
   rsp_word_type          merged;

   assign accept   = req_valid && !req_stall;
   assign wr_stamp = STAMP_BITS'(req_word.stamp);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_word.func == FUNC_RESOLVE) ? ST_FETCH : ST_MERGE;
            end
         end
         ST_FETCH: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      cmp_en    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_FETCH: begin
            cmp_en = 1'b1;
         end
         ST_MERGE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign wr_en = accept && (req_word.func == FUNC_WRITE) && (int'(req_word.node) < NODES);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[req_word.node[IDX_W-1:0]] = 1'b1;
      end
      // never-written entries read as zero
      att_stamp = valid_ff[item_ff.node[IDX_W-1:0]] ? ram_rdata : '0;

      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in = merged;
      end
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

   tcpa_ram #(
      .WIDTH (STAMP_BITS),
      .DEPTH (LANES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_word.node[IDX_W-1:0]),
      .wr_data (wr_stamp),
      .rd_en   (accept),
      .rd_addr (req_word.node[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lane_ctrl_type lane_ctrl;

      always_comb begin
         lane_ctrl.wr_en    = wr_en && (req_word.node[IDX_W-1:0] == IDX_W'(i));
         lane_ctrl.cmp_en   = cmp_en;
         lane_ctrl.att_node = item_ff.node;
      end

      tcpa_lane #(
         .STAMP_BITS (STAMP_BITS),
         .LANE_ID    (i)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .wr_stamp  (wr_stamp),
         .att_stamp (att_stamp),
         .beats_att (beat[i])
      );
   end

   tcpa_merge #(
      .NODES (NODES)
   ) u_merge (
      .item   (item_ff),
      .beat   (beat),
      .result (merged)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTH
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && state_ff == ST_IDLE))
      else $error("block not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_merge_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && rsp_valid && rsp_stall) |=>
      (state_ff == ST_MERGE && $stable(rsp_word)))
      else $error("merge overwrote a stalled response");

   a_loss_no_abort: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.attacker_wins) |-> (rsp_word.abort_mask == '0))
      else $error("losing attacker aborted nodes");
`endif

endmodule

FILE: verif/tx_conflict_priority_arbiter_core_tb.sv
`timescale 1ns / 1ps

module tx_conflict_priority_arbiter_core_tb;
   import tcpa_pkg::*;

   localparam int NODE_COUNT  = 64;
   localparam int STAMP_WIDTH = 32;
   localparam int LANE_COUNT  = (NODE_COUNT < MASK_BITS) ? NODE_COUNT : MASK_BITS;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 300;

   class conflict_scoreboard;
      logic [STAMP_WIDTH-1:0] node_stamp [NODE_COUNT];
      rsp_word_type           pending_verdicts [$];
      int                     mismatches;

      function new();
         foreach (node_stamp[i]) node_stamp[i] = '0;
         mismatches = 0;
      endfunction

      // lower stamp wins, ties go to the lower id
      function bit has_priority(int a, int b);
         return (node_stamp[a] < node_stamp[b]) ||
                (node_stamp[a] == node_stamp[b] && a < b);
      endfunction

      function rsp_word_type arbitrate(req_word_type w);
         rsp_word_type verdict;
         bit           lost;
         int           att;
         int           def;
         verdict = '0;
         lost    = 1'b0;
         att     = int'(w.node);
         def     = int'(w.single_defender);
         if (w.func == FUNC_WRITE) begin
            if (att < NODE_COUNT) node_stamp[att] = w.stamp[STAMP_WIDTH-1:0];
         end else if (att < NODE_COUNT) begin
            case (w.conflict_kind)
               KIND_RAW, KIND_WAW: begin
                  if (def < NODE_COUNT && has_priority(att, def)) begin
                     verdict.attacker_wins  = 1'b1;
                     verdict.abort_mask[def] = 1'b1;
                  end
               end
               KIND_WAR: begin
                  for (int i = 0; i < LANE_COUNT; i++)
                     if (w.reader_mask[i] && i != att && has_priority(i, att)) lost = 1'b1;
                  if (!lost) begin
                     verdict.attacker_wins = 1'b1;
                     for (int i = 0; i < LANE_COUNT; i++)
                        if (w.reader_mask[i] && i != att) verdict.abort_mask[i] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         return verdict;
      endfunction

      function void note_request(req_word_type w);
         pending_verdicts.push_back(arbitrate(w));
      endfunction

      task flag_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending_verdicts.size() == 0) begin
            flag_mismatch("response word with nothing outstanding");
         end else begin
            want = pending_verdicts.pop_front();
            if (got.attacker_wins !== want.attacker_wins)
               flag_mismatch($sformatf("attacker_wins got %b want %b",
                                       got.attacker_wins, want.attacker_wins));
            if (got.abort_mask !== want.abort_mask)
               flag_mismatch($sformatf("abort_mask got %h want %h",
                                       got.abort_mask, want.abort_mask));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   conflict_scoreboard scoreboard;
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_left = 0;

   tx_conflict_priority_arbiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #HALF_PERIOD clock = ~clock;

   // receiver: a long hold-off counts down here, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_response(rsp_word);
   end

   function req_word_type make_update(int node, logic [STAMP_IN_BITS-1:0] stamp);
      req_word_type w;
      w = '0;
      w.func  = FUNC_WRITE;
      w.node  = NODE_BITS'(node);
      w.stamp = stamp;
      return w;
   endfunction

   function req_word_type make_resolve(logic [1:0] kind, int node, int def,
                                       logic [MASK_BITS-1:0] mask);
      req_word_type w;
      w = '0;
      w.func            = FUNC_RESOLVE;
      w.node            = NODE_BITS'(node);
      w.conflict_kind   = kind;
      w.single_defender = NODE_BITS'(def);
      w.reader_mask     = mask;
      return w;
   endfunction

   function req_word_type make_random_request();
      req_word_type w;
      int           pick;
      int           bits;
      w.func            = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_RESOLVE;
      w.node            = NODE_BITS'($urandom_range(63));
      w.stamp           = $urandom;
      w.single_defender = NODE_BITS'($urandom_range(63));
      w.reader_mask     = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick < 3) w.conflict_kind = KIND_RAW;
      else if (pick < 5) w.conflict_kind = KIND_WAW;
      else if (pick < 9) w.conflict_kind = KIND_WAR;
      else w.conflict_kind = KIND_UNKNOWN;
      // small stamps make ties and wins common
      if (w.func == FUNC_WRITE && $urandom_range(1) == 0) w.stamp = $urandom_range(7);
      if (w.func == FUNC_RESOLVE && w.conflict_kind == KIND_WAR) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            w.reader_mask = '0;
            bits = $urandom_range(1, 3);
            repeat (bits) w.reader_mask[$urandom_range(63)] = 1'b1;
            if ($urandom_range(1) == 0) w.reader_mask[w.node] = 1'b1;
         end else if (pick == 5) begin
            w.reader_mask = '0;
         end else if (pick == 6) begin
            w.reader_mask = '0;
            w.reader_mask[w.node] = 1'b1;
         end
      end
      if (w.func == FUNC_RESOLVE && $urandom_range(19) == 0) w.single_defender = w.node;
      return w;
   endfunction

   task send_word(req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      scoreboard.note_request(w);
   endtask

   task drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (scoreboard.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task run_directed();
      logic [MASK_BITS-1:0] mask;
      // all stamps zero after reset: the id decides
      send_word(make_resolve(KIND_RAW, 0, 1, '0));
      send_word(make_resolve(KIND_RAW, 1, 0, '0));
      send_word(make_resolve(KIND_WAW, 5, 5, '1));
      send_word(make_update(63, '1));
      send_word(make_update(0, '0));
      send_word(make_update(10, 100));
      send_word(make_update(20, 50));
      send_word(make_resolve(KIND_RAW, 20, 10, '0));
      send_word(make_resolve(KIND_RAW, 10, 20, '0));
      send_word(make_resolve(KIND_WAW, 20, 63, '1));
      send_word(make_resolve(KIND_WAR, 20, 0, '0));
      mask = '0;
      mask[20] = 1'b1;
      send_word(make_resolve(KIND_WAR, 20, 0, mask));
      mask[10] = 1'b1;
      mask[63] = 1'b1;
      send_word(make_resolve(KIND_WAR, 20, 0, mask));
      send_word(make_resolve(KIND_WAR, 10, 0, mask));
      send_word(make_resolve(KIND_WAR, 0, 0, '1));
      send_word(make_resolve(KIND_UNKNOWN, 0, 1, '1));
      send_word(make_update(63, '0));
      send_word(make_resolve(KIND_WAW, 63, 0, '0));
      send_word(make_update(0, 32'h8000_0000));
      send_word(make_resolve(KIND_WAW, 63, 0, '0));
      send_word(make_resolve(KIND_WAR, 63, 63, '1));
      send_word(make_resolve(KIND_WAR, 0, 63, '1));
      send_word(make_update(0, 32'h7FFF_FFFF));
      send_word(make_resolve(KIND_RAW, 0, 10, '0));
      drain();
   endtask

   task run_phase(int idle, int stall, int count);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_word(make_random_request());
      drain();
   endtask

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      scoreboard = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_phase(0, 0, 250);
      run_phase(82, 0, 250);
      run_phase(0, 82, 250);
      run_phase(14, 14, 250);
      // receiver holds off while words keep coming, so the input backs up
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = HOLD_CYCLES;
      run_phase(0, 0, 60);
      if (scoreboard.mismatches == 0 && scoreboard.pending_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
